// File: rtl/ddm_pkg.sv
// ddm_pkg: shared types, states and digit helpers for the decimal digit multiplier.
// No dependencies; imported by decimal_digit_multiplier_unit and ddm_checker.
`timescale 1ns / 1ps
package ddm_pkg;

  localparam logic [3:0] DIGIT_MAX = 4'd9;

  typedef struct packed {
    logic       req_type;
    logic [3:0] digit;
    logic       operand_negative;
    logic [5:0] frac_digits;
    logic       last_digit;
  } ddm_in_t;

  typedef struct packed {
    logic [3:0] product_digit;
    logic       product_negative;
    logic [6:0] product_frac_digits;
    logic       last;
  } ddm_out_t;

  typedef enum logic {
    PH_FIRST  = 1'b0,
    PH_SECOND = 1'b1
  } ddm_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_LD_A,
    ST_RD_M,
    ST_MAC,
    ST_RD_C,
    ST_ADD_C,
    ST_EMIT
  } ddm_state_t;

  typedef struct packed {
    logic [3:0] quo;
    logic [3:0] rem;
  } ddm_qr_t;

  // t / 10 via reciprocal 205/2048, exact for t < 1029
  function automatic ddm_qr_t div10(input logic [6:0] t);
    logic [14:0] prod;
    logic [6:0]  back;
    ddm_qr_t     res;
    prod     = {8'd0, t} * 15'd205;
    res.quo  = prod[14:11];
    back     = t - ({3'd0, res.quo} * 7'd10);
    res.rem  = back[3:0];
    return res;
  endfunction

endpackage

// File: rtl/ddm_ram.sv
// ddm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ddm_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/decimal_digit_multiplier_unit.sv
// decimal_digit_multiplier_unit: signed decimal schoolbook multiplier, digit serial.
// Depends on ddm_pkg and ddm_ram (operand stores and product store).
//
//   channel  | ports                       | transfer
//   ---------+-----------------------------+----------------------------------
//   input    | start, busy, in_item        | start & !busy at clock edge
//   result   | out_strobe, out_item        | one digit per cycle, no backpressure
//
// Loading: one digit item per cycle while busy is low. The last digit of the second
// operand starts the product: a read and a load state fetch each first-operand digit,
// a digit step is a read and a multiply-add state, a carry step a read and an add
// state, then the emit state streams all 2*MAX_DIGITS digits, the last reaching the
// ports through iss_r and the output register after busy falls. The pace is set by
// the single digit multiply-add unit and the one read port of the product RAM.
// Reset is synchronous; valid bits clear the product store as each product begins.
`timescale 1ns / 1ps
module decimal_digit_multiplier_unit #(
  parameter int MAX_DIGITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ddm_pkg::ddm_in_t  in_item,
  output logic              out_strobe,
  output ddm_pkg::ddm_out_t out_item
);
  import ddm_pkg::*;

  localparam int PROD   = 2 * MAX_DIGITS;
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int PIDX_W = $clog2(PROD);

  ddm_state_t          state_r, state_nxt;
  ddm_phase_t          phase_r, phase_nxt;
  logic [CNT_W-1:0]    fc_r, fc_nxt, sc_r, sc_nxt;
  logic                neg_a_r, neg_a_nxt;
  logic [5:0]          frac_a_r, frac_a_nxt;
  logic                pneg_r, pneg_nxt;
  logic [6:0]          pfrac_r, pfrac_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt, j_r, j_nxt;
  logic [3:0]          a_r, a_nxt, carry_r, carry_nxt;
  logic [PIDX_W-1:0]   pos_r, pos_nxt, k_r, k_nxt;
  logic [PROD-1:0]     pv_r, pv_nxt;
  logic                pv_q_r;
  logic                iss_r, iss_nxt, iss_last_r, iss_last_nxt;
  logic                out_strobe_r;
  ddm_out_t            out_r;

  logic                accept;
  logic [3:0]          din;
  logic                a_we, b_we, p_we;
  logic [IDX_W-1:0]    a_waddr, b_waddr, a_raddr, b_raddr;
  logic [PIDX_W-1:0]   p_waddr, p_raddr;
  logic [3:0]          p_wdata, a_rdata, b_rdata, p_rdata, p_eff;
  logic [CNT_W-1:0]    a_idx, b_idx;
  logic [PIDX_W-1:0]   pos_calc;
  logic [7:0]          mul;
  logic [6:0]          t_sum;
  ddm_qr_t             qr;
  logic                next_row, last_row;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign din    = (in_item.digit > DIGIT_MAX) ? DIGIT_MAX : in_item.digit;

  assign a_idx    = fc_r - CNT_W'(1) - i_r;
  assign b_idx    = sc_r - CNT_W'(1) - j_r;
  assign a_raddr  = a_idx[IDX_W-1:0];
  assign b_raddr  = b_idx[IDX_W-1:0];
  assign a_waddr  = fc_r[IDX_W-1:0];
  assign b_waddr  = sc_r[IDX_W-1:0];
  assign pos_calc = PIDX_W'(PROD - 1) - (PIDX_W'(i_r) + PIDX_W'(j_r));
  assign p_eff    = pv_q_r ? p_rdata : 4'd0;
  assign mul      = {4'd0, a_r} * {4'd0, b_rdata};
  assign last_row = (i_r + CNT_W'(1) == fc_r);

  // digit step adds the partial product, carry step only the carry
  assign t_sum = {3'd0, p_eff} + ((state_r == ST_MAC) ? mul[6:0] : 7'd0)
               + {3'd0, carry_r};

  always_comb begin
    a_we = 1'b0;
    b_we = 1'b0;
    if (accept && (in_item.req_type == logic'(phase_r))) begin
      a_we = (phase_r == PH_FIRST)  && (fc_r < CNT_W'(MAX_DIGITS));
      b_we = (phase_r == PH_SECOND) && (sc_r < CNT_W'(MAX_DIGITS));
    end
  end

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    fc_nxt       = fc_r;
    sc_nxt       = sc_r;
    neg_a_nxt    = neg_a_r;
    frac_a_nxt   = frac_a_r;
    pneg_nxt     = pneg_r;
    pfrac_nxt    = pfrac_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    a_nxt        = a_r;
    carry_nxt    = carry_r;
    pos_nxt      = pos_r;
    k_nxt        = k_r;
    pv_nxt       = pv_r;
    iss_nxt      = 1'b0;
    iss_last_nxt = 1'b0;
    p_we         = 1'b0;
    p_waddr      = pos_r;
    p_wdata      = 4'd0;
    p_raddr      = pos_r;
    next_row     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_item.req_type == logic'(phase_r))) begin
          if (phase_r == PH_FIRST) begin
            if (a_we) fc_nxt = fc_r + CNT_W'(1);
            neg_a_nxt  = in_item.operand_negative;
            frac_a_nxt = in_item.frac_digits;
            if (in_item.last_digit) phase_nxt = PH_SECOND;
          end else begin
            if (b_we) sc_nxt = sc_r + CNT_W'(1);
            if (in_item.last_digit) begin
              pneg_nxt  = neg_a_r ^ in_item.operand_negative;
              pfrac_nxt = {1'b0, frac_a_r} + {1'b0, in_item.frac_digits};
              phase_nxt = PH_FIRST;
              pv_nxt    = '0;
              i_nxt     = '0;
              state_nxt = ST_RD_A;
            end
          end
        end
      end
      ST_RD_A: begin
        state_nxt = ST_LD_A;
      end
      ST_LD_A: begin
        a_nxt     = a_rdata;
        carry_nxt = 4'd0;
        j_nxt     = '0;
        state_nxt = ST_RD_M;
      end
      ST_RD_M: begin
        pos_nxt   = pos_calc;
        p_raddr   = pos_calc;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        p_we          = 1'b1;
        p_wdata       = qr.rem;
        pv_nxt[pos_r] = 1'b1;
        carry_nxt     = qr.quo;
        j_nxt         = j_r + CNT_W'(1);
        if (j_r + CNT_W'(1) == sc_r) begin
          if ((qr.quo != 4'd0) && (pos_r != '0)) begin
            pos_nxt   = pos_r - PIDX_W'(1);
            state_nxt = ST_RD_C;
          end else begin
            next_row = 1'b1;
          end
        end else begin
          state_nxt = ST_RD_M;
        end
      end
      ST_RD_C: begin
        state_nxt = ST_ADD_C;
      end
      ST_ADD_C: begin
        p_we          = 1'b1;
        p_wdata       = qr.rem;
        pv_nxt[pos_r] = 1'b1;
        carry_nxt     = qr.quo;
        if ((qr.quo != 4'd0) && (pos_r != '0)) begin
          pos_nxt   = pos_r - PIDX_W'(1);
          state_nxt = ST_RD_C;
        end else begin
          next_row = 1'b1;
        end
      end
      ST_EMIT: begin
        p_raddr      = k_r;
        iss_nxt      = 1'b1;
        iss_last_nxt = (k_r == PIDX_W'(PROD - 1));
        k_nxt        = k_r + PIDX_W'(1);
        if (k_r == PIDX_W'(PROD - 1)) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (next_row) begin
      i_nxt = i_r + CNT_W'(1);
      if (last_row) begin
        fc_nxt    = '0;
        sc_nxt    = '0;
        k_nxt     = '0;
        state_nxt = ST_EMIT;
      end else begin
        state_nxt = ST_RD_A;
      end
    end
  end

  assign qr = div10(t_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_FIRST;
      fc_r         <= '0;
      sc_r         <= '0;
      neg_a_r      <= 1'b0;
      frac_a_r     <= '0;
      pv_r         <= '0;
      iss_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      fc_r         <= fc_nxt;
      sc_r         <= sc_nxt;
      neg_a_r      <= neg_a_nxt;
      frac_a_r     <= frac_a_nxt;
      pv_r         <= pv_nxt;
      iss_r        <= iss_nxt;
      out_strobe_r <= iss_r;
    end
  end

  always_ff @(posedge clk) begin
    pneg_r     <= pneg_nxt;
    pfrac_r    <= pfrac_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    a_r        <= a_nxt;
    carry_r    <= carry_nxt;
    pos_r      <= pos_nxt;
    k_r        <= k_nxt;
    iss_last_r <= iss_last_nxt;
    pv_q_r     <= pv_r[p_raddr];
    out_r.product_digit       <= p_eff;
    out_r.product_negative    <= pneg_r;
    out_r.product_frac_digits <= pfrac_r;
    out_r.last                <= iss_last_r;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  ddm_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (din),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  ddm_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (din),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  ddm_ram #(.WIDTH(4), .DEPTH(PROD)) u_ram_p (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

endmodule

// File: rtl/ddm_checker.sv
// ddm_checker: port-level assertions for decimal_digit_multiplier_unit.
// Depends on ddm_pkg; bound to the top level below.
`timescale 1ns / 1ps
module ddm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input ddm_pkg::ddm_in_t  in_item,
  input logic              out_strobe,
  input ddm_pkg::ddm_out_t out_item
);
  import ddm_pkg::*;

  // product digits stream without gaps until the final one
  a_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |=> out_strobe)
    else $error("gap in product digit stream");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.last |=> !out_strobe)
    else $error("digit after final product digit");

  a_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.product_digit <= DIGIT_MAX))
    else $error("product digit out of decimal range");

  // sign and scale hold for a whole product transaction
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |=>
      $stable(out_item.product_negative) && $stable(out_item.product_frac_digits))
    else $error("sign or fraction count changed within a product");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_strobe)
    else $error("busy or strobe after reset");

endmodule

bind decimal_digit_multiplier_unit ddm_checker u_ddm_checker (.*);
